FILE: design/oaht_pkg.sv
// Shared constants for the open-addressed hash table.
// Used by the top level and by its checker; no dependencies.
`default_nettype none

package oaht_pkg;

    localparam int SLOTS      = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int HASH_BITS  = 32;

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int ENTRY_W = KEY_BITS + VALUE_BITS;

    // insert refused once it would raise the load above one half
    localparam logic [CNT_W-1:0] HALF_COUNT = CNT_W'(SLOTS / 2);
    localparam logic [IDX_W-1:0] LAST_STEP  = IDX_W'(SLOTS - 1);

    localparam logic KIND_FIND   = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

endpackage

`default_nettype wire

FILE: design/open_addressing_hash_table.sv
// Open-addressed hash table with triangular probing, fixed capacity.
// Depends on oaht_pkg for sizes and status codes.
//
// Usage:
//   Input channel (s_*): one request per transfer. s_kind selects find or
//   insert; s_hash low bits give the first slot, s_key is matched for
//   equality, s_value is stored on insert.
//   Result channel (m_*): exactly one result per request, in order:
//   m_status (ok / not found / full) and m_found_value (value on a find hit,
//   else zero).
//   Timing: the probe stage reads one slot per cycle from the key/value RAM
//   (one registered read port, one write port). A hit or empty slot on the
//   first probe is decided from the registered RAM read and is then
//   registered into m_valid; a refused insert ends on its first probe.
//   Stall: the result sits in an output register; a new request is accepted
//   while it waits. If a second result is ready before the first is taken,
//   the probe stage holds until the output register frees.
//   Reset: synchronous, active low. Clears the state, slot-used bits, entry
//   count and m_valid; key/value RAM and result data are not cleared.
`default_nettype none

module open_addressing_hash_table (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_kind,
    input  wire logic [oaht_pkg::KEY_BITS-1:0]   s_key,
    input  wire logic [oaht_pkg::HASH_BITS-1:0]  s_hash,
    input  wire logic [oaht_pkg::VALUE_BITS-1:0] s_value,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [1:0]                           m_status,
    output logic [oaht_pkg::VALUE_BITS-1:0]      m_found_value
);

    typedef enum logic {
        S_IDLE,
        S_PROBE
    } state_t;

    state_t state_reg, state_next;

    logic                              kind_reg, kind_next;
    logic [oaht_pkg::KEY_BITS-1:0]     key_reg, key_next;
    logic [oaht_pkg::VALUE_BITS-1:0]   value_reg, value_next;
    logic                              full_reg, full_next;
    logic [oaht_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [oaht_pkg::IDX_W-1:0]        step_reg, step_next;
    logic [oaht_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [oaht_pkg::SLOTS-1:0]        used_reg, used_next;

    logic                              m_valid_reg, m_valid_next;
    logic [1:0]                        m_status_reg, m_status_next;
    logic [oaht_pkg::VALUE_BITS-1:0]   m_found_value_reg, m_found_value_next;

    // key/value RAM, one read port (registered) and one write port
    logic [oaht_pkg::ENTRY_W-1:0] entry_mem [oaht_pkg::SLOTS];
    logic [oaht_pkg::ENTRY_W-1:0] rd_data_reg;
    logic [oaht_pkg::IDX_W-1:0]   rd_addr;
    logic                         wr_en;

    logic [oaht_pkg::KEY_BITS-1:0]   rd_key;
    logic [oaht_pkg::VALUE_BITS-1:0] rd_value;
    logic [oaht_pkg::IDX_W:0]        idx_sum;
    logic [oaht_pkg::IDX_W-1:0]      idx_adv;
    logic                            accept;
    logic                            slot_used;
    logic                            key_match;
    logic                            last_step;
    logic                            done;
    logic                            advance;
    logic                            out_free;
    logic                            finish;
    logic [1:0]                      res_status;
    logic [oaht_pkg::VALUE_BITS-1:0] res_value;

    assign s_ready       = (state_reg == S_IDLE);
    assign accept        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_found_value = m_found_value_reg;

    assign rd_key    = rd_data_reg[oaht_pkg::ENTRY_W-1:oaht_pkg::VALUE_BITS];
    assign rd_value  = rd_data_reg[oaht_pkg::VALUE_BITS-1:0];
    assign slot_used = used_reg[idx_reg];
    assign key_match = (rd_key == key_reg);
    assign last_step = (step_reg == oaht_pkg::LAST_STEP);
    assign idx_sum   = {1'b0, idx_reg} + {1'b0, step_reg} + (oaht_pkg::IDX_W + 1)'(1);
    assign idx_adv   = idx_sum[oaht_pkg::IDX_W-1:0];
    assign out_free  = !m_valid_reg || m_ready;

    // probe decision for the slot at idx_reg
    always_comb begin
        done       = 1'b0;
        advance    = 1'b0;
        res_status = oaht_pkg::ST_MISSING;
        res_value  = '0;
        if (full_reg) begin
            done       = 1'b1;
            res_status = oaht_pkg::ST_FULL;
        end else if (kind_reg == oaht_pkg::KIND_INSERT) begin
            if (!slot_used) begin
                done       = 1'b1;
                res_status = oaht_pkg::ST_OK;
            end else if (last_step) begin
                done       = 1'b1;
                res_status = oaht_pkg::ST_FULL;
            end else begin
                advance = 1'b1;
            end
        end else begin
            if (!slot_used) begin
                done       = 1'b1;
                res_status = oaht_pkg::ST_MISSING;
            end else if (key_match) begin
                done       = 1'b1;
                res_status = oaht_pkg::ST_OK;
                res_value  = rd_value;
            end else if (last_step) begin
                done       = 1'b1;
                res_status = oaht_pkg::ST_MISSING;
            end else begin
                advance = 1'b1;
            end
        end
    end

    assign finish = (state_reg == S_PROBE) && done && out_free;
    assign wr_en  = finish && !full_reg && (kind_reg == oaht_pkg::KIND_INSERT) && !slot_used;

    // while waiting on the output register the current slot is simply re-read
    always_comb begin
        if (state_reg == S_IDLE) begin
            rd_addr = s_hash[oaht_pkg::IDX_W-1:0];
        end else if (advance) begin
            rd_addr = idx_adv;
        end else begin
            rd_addr = idx_reg;
        end
    end

    always_comb begin
        state_next         = state_reg;
        kind_next          = kind_reg;
        key_next           = key_reg;
        value_next         = value_reg;
        full_next          = full_reg;
        idx_next           = idx_reg;
        step_next          = step_reg;
        count_next         = count_reg;
        used_next          = used_reg;
        m_valid_next       = m_valid_reg;
        m_status_next      = m_status_reg;
        m_found_value_next = m_found_value_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    kind_next  = s_kind;
                    key_next   = s_key;
                    value_next = s_value;
                    full_next  = (s_kind == oaht_pkg::KIND_INSERT) &&
                                 (count_reg >= oaht_pkg::HALF_COUNT);
                    idx_next   = s_hash[oaht_pkg::IDX_W-1:0];
                    step_next  = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (advance) begin
                    idx_next  = idx_adv;
                    step_next = step_reg + oaht_pkg::IDX_W'(1);
                end else if (finish) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = res_status;
                    m_found_value_next = res_value;
                    state_next         = S_IDLE;
                    if (wr_en) begin
                        used_next[idx_reg] = 1'b1;
                        count_next         = count_reg + oaht_pkg::CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg          <= kind_next;
        key_reg           <= key_next;
        value_reg         <= value_next;
        full_reg          <= full_next;
        idx_reg           <= idx_next;
        step_reg          <= step_next;
        m_status_reg      <= m_status_next;
        m_found_value_reg <= m_found_value_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[idx_reg] <= {key_reg, value_reg};
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: design/oaht_checker.sv
// Port-level checks for open_addressing_hash_table, attached by bind.
// Depends on oaht_pkg for status codes.
`default_nettype none

module oaht_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [1:0]                      m_status,
    input wire logic [oaht_pkg::VALUE_BITS-1:0] m_found_value
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_found_value))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == oaht_pkg::ST_OK || m_status == oaht_pkg::ST_MISSING ||
                     m_status == oaht_pkg::ST_FULL))
        else $error("illegal status code");

    // only a find hit carries a value; misses and refusals return zero
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != oaht_pkg::ST_OK |-> m_found_value == '0)
        else $error("nonzero value on miss or refusal");

    // the table is busy probing after every request transfer, so s_ready drops
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted back to back");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_found_value (m_found_value)
);

`default_nettype wire
